// ----- hw/rtl/stt_pkg.sv -----
// ----------------------------------------------------------------------------
// stt_pkg
// Shared types, constants and helpers of the station table with resend
// schedule: word types, per-entry record, controller commands and status.
// ----------------------------------------------------------------------------
`default_nettype none

package stt_pkg;

    // sizing defaults
    localparam int ENTRIES_DEF     = 32;
    localparam int MAX_REPEATS_DEF = 4;
    localparam int MAX_OUT         = 32;
    localparam int EW              = 5;    // entry field width
    localparam int CW              = 6;    // corral slot width
    localparam int OUT_CNT_W       = 6;    // holds 0..MAX_OUT

    localparam logic [7:0]  BLANK    = 8'h20;
    localparam logic [31:0] TIME_MAX = 32'hFFFF_FFFF;

    // configuration register indexes
    localparam logic [2:0] CFG_REPEAT = 3'd0;
    localparam logic [2:0] CFG_DLY1   = 3'd1;
    localparam logic [2:0] CFG_DLY2   = 3'd2;
    localparam logic [2:0] CFG_DLY3   = 3'd3;
    localparam logic [2:0] CFG_DLY4   = 3'd4;
    localparam logic [2:0] CFG_RETAIN = 3'd5;

    // input opcodes
    localparam logic OP_HEARD = 1'b0;
    localparam logic OP_TICK  = 1'b1;

    // result kinds
    localparam logic [1:0] KIND_HEARD   = 2'd0;
    localparam logic [1:0] KIND_NOCALL  = 2'd1;
    localparam logic [1:0] KIND_REPORT  = 2'd2;
    localparam logic [1:0] KIND_NOREP   = 2'd3;

    typedef struct packed {
        logic        opcode;
        logic [63:0] call_low;
        logic [7:0]  call_high;
        logic [7:0]  overlay;
        logic [9:0]  call_suffix;
        logic        has_position;
    } t_in;

    typedef struct packed {
        logic [1:0]    kind;
        logic [EW-1:0] entry;
        logic [CW-1:0] corral_pos;
        logic [1:0]    repeat_number;
        logic [7:0]    overlay_out;
        logic [31:0]   heard_time;
        logic          last;
    } t_res;

    // one table entry as held in the memory
    typedef struct packed {
        logic [63:0]   call_low;
        logic [7:0]    call_high;
        logic [7:0]    overlay;
        logic [9:0]    suffix;
        logic [31:0]   heard;
        logic [2:0]    reps;
        logic [31:0]   due;
        logic [CW-1:0] corral;
    } t_entry;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_LK_RD,
        ST_LK_EV,
        ST_DECIDE,
        ST_SB_RD,
        ST_SB_EV,
        ST_SL_SRCH,
        ST_UP_RD,
        ST_UP_WR,
        ST_TK_RD,
        ST_TK_EV,
        ST_TK_FIN
    } t_state;

    typedef struct packed {
        logic load_hear;
        logic load_tick;
        logic emit_empty;
        logic rd_cnt;
        logic rd_tgt;
        logic lk_ev;
        logic decide;
        logic sb_ev;
        logic sl_step;
        logic upd;
        logic tk_ev;
        logic tk_fin;
    } t_cmd;

    typedef struct packed {
        logic empty;
        logic cnt_end;
        logic need_slot;
        logic slot_free;
    } t_sts;

    // saturating 32-bit add
    function automatic logic [31:0] add_sat(input logic [31:0] a, input logic [31:0] b);
        logic [32:0] s;
        s = {1'b0, a} + {1'b0, b};
        return s[32] ? TIME_MAX : s[31:0];
    endfunction

endpackage

`default_nettype wire

// ----- hw/rtl/station_table_with_resend_schedule.sv -----
// ----------------------------------------------------------------------------
// station_table_with_resend_schedule
// Table of recently heard stations with a per-entry report resend schedule.
//
//   channel   signals                              direction
//   command   i_start, o_busy, i_in                in
//   config    i_cfg_we, i_cfg_idx, i_cfg_data      in
//   result    o_res_valid, o_res                   out
//
// A hearing scans every entry with one read of the entry memory each, then
// reads and writes the target entry; a new entry that needs a corral slot adds
// a second scan and a slot search before that. A tick scans every entry; each
// report word is held until the next due entry is found, the final one at the
// end. An empty call is answered without a scan. Reset clears valid bits and
// the clock and restores config defaults; results cannot be held off.
// ----------------------------------------------------------------------------
`default_nettype none

module station_table_with_resend_schedule #(
    parameter int ENTRIES     = stt_pkg::ENTRIES_DEF,
    parameter int MAX_REPEATS = stt_pkg::MAX_REPEATS_DEF
) (
    input  wire logic         i_clk,
    input  wire logic         i_rst_n,
    input  wire logic         i_start,
    output logic              o_busy,
    input  wire stt_pkg::t_in i_in,
    input  wire logic         i_cfg_we,
    input  wire logic [2:0]   i_cfg_idx,
    input  wire logic [15:0]  i_cfg_data,
    output logic              o_res_valid,
    output stt_pkg::t_res     o_res
);

    stt_pkg::t_cmd cmd;
    stt_pkg::t_sts sts;

    // sequencer
    stt_ctrl u_ctrl (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (i_start),
        .i_op    (i_in.opcode),
        .i_sts   (sts),
        .o_cmd   (cmd),
        .o_busy  (o_busy)
    );

    // table and scheduling datapath
    stt_dp #(
        .ENTRIES     (ENTRIES),
        .MAX_REPEATS (MAX_REPEATS)
    ) u_dp (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in        (i_in),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_idx   (i_cfg_idx),
        .i_cfg_data  (i_cfg_data),
        .i_cmd       (cmd),
        .o_sts       (sts),
        .o_res_valid (o_res_valid),
        .o_res       (o_res)
    );

endmodule

`default_nettype wire

// ----- hw/rtl/stt_ctrl.sv -----
// ----------------------------------------------------------------------------
// stt_ctrl
// Controller: sequences lookup, slot search, update and tick scans.
// ----------------------------------------------------------------------------
`default_nettype none

module stt_ctrl (
    input  wire logic          i_clk,
    input  wire logic          i_rst_n,
    input  wire logic          i_start,
    input  wire logic          i_op,
    input  wire stt_pkg::t_sts i_sts,
    output stt_pkg::t_cmd      o_cmd,
    output logic               o_busy
);

    stt_pkg::t_state r_state, n_state;

    // state register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= stt_pkg::ST_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    // next state and commands
    always_comb begin
        n_state = r_state;
        o_cmd   = '0;
        unique case (r_state)
            stt_pkg::ST_IDLE: begin
                if (i_start) begin
                    if (i_op == stt_pkg::OP_TICK) begin
                        o_cmd.load_tick = 1'b1;
                        n_state = stt_pkg::ST_TK_RD;
                    end else if (i_sts.empty) begin
                        o_cmd.emit_empty = 1'b1;
                    end else begin
                        o_cmd.load_hear = 1'b1;
                        n_state = stt_pkg::ST_LK_RD;
                    end
                end
            end
            stt_pkg::ST_LK_RD: begin
                o_cmd.rd_cnt = 1'b1;
                n_state = stt_pkg::ST_LK_EV;
            end
            stt_pkg::ST_LK_EV: begin
                o_cmd.lk_ev = 1'b1;
                n_state = i_sts.cnt_end ? stt_pkg::ST_DECIDE : stt_pkg::ST_LK_RD;
            end
            stt_pkg::ST_DECIDE: begin
                o_cmd.decide = 1'b1;
                n_state = i_sts.need_slot ? stt_pkg::ST_SB_RD : stt_pkg::ST_UP_RD;
            end
            stt_pkg::ST_SB_RD: begin
                o_cmd.rd_cnt = 1'b1;
                n_state = stt_pkg::ST_SB_EV;
            end
            stt_pkg::ST_SB_EV: begin
                o_cmd.sb_ev = 1'b1;
                n_state = i_sts.cnt_end ? stt_pkg::ST_SL_SRCH : stt_pkg::ST_SB_RD;
            end
            stt_pkg::ST_SL_SRCH: begin
                if (i_sts.slot_free) begin
                    n_state = stt_pkg::ST_UP_RD;
                end else begin
                    o_cmd.sl_step = 1'b1;
                end
            end
            stt_pkg::ST_UP_RD: begin
                o_cmd.rd_tgt = 1'b1;
                n_state = stt_pkg::ST_UP_WR;
            end
            stt_pkg::ST_UP_WR: begin
                o_cmd.upd = 1'b1;
                n_state = stt_pkg::ST_IDLE;
            end
            stt_pkg::ST_TK_RD: begin
                o_cmd.rd_cnt = 1'b1;
                n_state = stt_pkg::ST_TK_EV;
            end
            stt_pkg::ST_TK_EV: begin
                o_cmd.tk_ev = 1'b1;
                n_state = i_sts.cnt_end ? stt_pkg::ST_TK_FIN : stt_pkg::ST_TK_RD;
            end
            stt_pkg::ST_TK_FIN: begin
                o_cmd.tk_fin = 1'b1;
                n_state = stt_pkg::ST_IDLE;
            end
            default: begin
                n_state = stt_pkg::ST_IDLE;
            end
        endcase
    end

    assign o_busy = (r_state != stt_pkg::ST_IDLE);

endmodule

`default_nettype wire

// ----- hw/rtl/stt_dp.sv -----
// ----------------------------------------------------------------------------
// stt_dp
// Datapath: entry memory, valid bits, config registers, seconds clock,
// lookup trackers, corral slot bitmap and result word register.
// ----------------------------------------------------------------------------
`default_nettype none

module stt_dp #(
    parameter int ENTRIES     = stt_pkg::ENTRIES_DEF,
    parameter int MAX_REPEATS = stt_pkg::MAX_REPEATS_DEF
) (
    input  wire logic          i_clk,
    input  wire logic          i_rst_n,
    input  wire stt_pkg::t_in  i_in,
    input  wire logic          i_cfg_we,
    input  wire logic [2:0]    i_cfg_idx,
    input  wire logic [15:0]   i_cfg_data,
    input  wire stt_pkg::t_cmd i_cmd,
    output stt_pkg::t_sts      o_sts,
    output logic               o_res_valid,
    output stt_pkg::t_res      o_res
);

    localparam int IW = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
    localparam int EW = stt_pkg::EW;
    localparam int CW = stt_pkg::CW;
    localparam int OW = stt_pkg::OUT_CNT_W;

    // entry memory and valid bits
    stt_pkg::t_entry m_tab [ENTRIES];
    stt_pkg::t_entry r_rd;
    logic [ENTRIES-1:0] r_valid;

    // config
    logic [2:0]  r_rep;
    logic [15:0] r_dly [4];
    logic [15:0] r_ret;

    // item and scan state
    logic [31:0] r_clk;
    logic [63:0] r_lo;
    logic [7:0]  r_hi, r_ov;
    logic [9:0]  r_suf, r_dv;
    logic        r_pos, r_dvok;
    logic [IW-1:0] r_cnt;
    logic        r_m1f, r_m2f, r_m3f, r_frf;
    logic [IW-1:0] r_m1, r_m2, r_m3, r_fr, r_old, r_tgt;
    logic [31:0] r_oldh;
    logic        r_new;
    logic [(1<<CW)-1:0] r_bmp;
    logic [CW-1:0] r_slot;
    logic [OW-1:0] r_n;
    stt_pkg::t_res r_pend;
    logic        r_pendv;
    stt_pkg::t_res r_res;
    logic        r_resv;

    // call normalization: cut at first zero character
    logic [63:0] lo_norm;
    logic [7:0]  hi_norm;
    logic        dv_ok;
    logic [9:0]  dv_val;
    always_comb begin
        logic alive;
        alive = 1'b1;
        for (int b = 0; b < 8; b++) begin
            alive = alive & (i_in.call_low[8*b +: 8] != 8'h00);
            lo_norm[8*b +: 8] = alive ? i_in.call_low[8*b +: 8] : 8'h00;
        end
        hi_norm = alive ? i_in.call_high : 8'h00;
    end

    // exactly three ascii digits
    always_comb begin
        logic [7:0] c0, c1, c2;
        c0 = lo_norm[7:0];
        c1 = lo_norm[15:8];
        c2 = lo_norm[23:16];
        dv_ok = (hi_norm == 8'h00) && (lo_norm[63:24] == 40'h0)
            && (c0 >= 8'h30) && (c0 <= 8'h39)
            && (c1 >= 8'h30) && (c1 <= 8'h39)
            && (c2 >= 8'h30) && (c2 <= 8'h39);
        dv_val = 10'(c0[3:0]) * 10'd100 + 10'(c1[3:0]) * 10'd10 + 10'(c2[3:0]);
    end

    // repeat limit
    logic [2:0] lim;
    assign lim = (r_rep > 3'(MAX_REPEATS)) ? 3'(MAX_REPEATS) : r_rep;

    logic [IW-1:0] cnt_nxt;
    assign cnt_nxt = IW'({1'b0, r_cnt} + 1'b1);

    logic cur_v;
    assign cur_v = r_valid[r_cnt];

    // entry index to result field width
    function automatic logic [EW-1:0] ent_field(input logic [IW-1:0] idx);
        logic [IW+EW-1:0] t;
        t = {{EW{1'b0}}, idx};
        return t[EW-1:0];
    endfunction

    // lookup hit selection
    logic          hit;
    logic [IW-1:0] hit_idx;
    always_comb begin
        hit = 1'b0;
        hit_idx = r_m1;
        priority if (r_m1f) begin
            hit = 1'b1;
            hit_idx = r_m1;
        end else if (r_dvok && (r_ov != stt_pkg::BLANK) && r_m2f) begin
            hit = 1'b1;
            hit_idx = r_m2;
        end else if (r_dvok && (r_ov == stt_pkg::BLANK) && r_m3f) begin
            hit = 1'b1;
            hit_idx = r_m3;
        end else begin
            hit = 1'b0;
        end
    end

    // entry update for hearing
    stt_pkg::t_entry up_w;
    always_comb begin
        up_w = r_rd;
        if (r_new) begin
            up_w.call_low  = r_lo;
            up_w.call_high = r_hi;
            up_w.overlay   = r_ov;
            up_w.suffix    = r_suf;
            up_w.corral    = r_pos ? '0 : r_slot;
        end else if (r_pos) begin
            up_w.corral = '0;
        end
        up_w.heard = r_clk;
        up_w.reps  = 3'd0;
        up_w.due   = stt_pkg::add_sat(r_clk, {16'h0, r_dly[0]});
    end

    // report check and schedule advance for tick
    logic            tk_due, tk_purge;
    stt_pkg::t_entry tk_w;
    stt_pkg::t_res   tk_res;
    always_comb begin
        logic [32:0] expiry;
        tk_due = cur_v && (r_rd.reps < lim) && (r_rd.due <= r_clk)
            && (r_n < OW'(stt_pkg::MAX_OUT));
        expiry = {1'b0, r_rd.heard} + {17'h0, r_ret};
        tk_purge = cur_v && (expiry < {1'b0, r_clk});
        tk_w = r_rd;
        tk_w.reps = r_rd.reps + 3'd1;
        if (tk_w.reps < lim) begin
            tk_w.due = stt_pkg::add_sat(r_rd.due, {16'h0, r_dly[tk_w.reps[1:0]]});
        end
        tk_res.kind          = stt_pkg::KIND_REPORT;
        tk_res.entry         = ent_field(r_cnt);
        tk_res.corral_pos    = r_rd.corral;
        tk_res.repeat_number = r_rd.reps[1:0];
        tk_res.overlay_out   = r_rd.overlay;
        tk_res.heard_time    = r_rd.heard;
        tk_res.last          = 1'b0;
    end

    // memory port
    logic            mem_we;
    logic [IW-1:0]   mem_wa;
    stt_pkg::t_entry mem_wd;
    always_comb begin
        mem_we = 1'b0;
        mem_wa = r_cnt;
        mem_wd = tk_w;
        if (i_cmd.upd) begin
            mem_we = 1'b1;
            mem_wa = r_tgt;
            mem_wd = up_w;
        end else if (i_cmd.tk_ev && tk_due) begin
            mem_we = 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (mem_we) begin
            m_tab[mem_wa] <= mem_wd;
        end
        if (i_cmd.rd_cnt) begin
            r_rd <= m_tab[r_cnt];
        end else if (i_cmd.rd_tgt) begin
            r_rd <= m_tab[r_tgt];
        end
    end

    // control state: valid bits, config, clock, result strobe
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= '0;
            r_rep   <= 3'd3;
            r_dly[0] <= 16'd5;
            r_dly[1] <= 16'd8;
            r_dly[2] <= 16'd13;
            r_dly[3] <= 16'd13;
            r_ret   <= 16'd4800;
            r_clk   <= '0;
            r_resv  <= 1'b0;
            r_pendv <= 1'b0;
        end else begin
            r_resv <= i_cmd.emit_empty || i_cmd.upd || i_cmd.tk_fin
                || (i_cmd.tk_ev && tk_due && r_pendv);
            if (i_cfg_we) begin
                unique case (i_cfg_idx)
                    stt_pkg::CFG_REPEAT: r_rep    <= i_cfg_data[2:0];
                    stt_pkg::CFG_DLY1:   r_dly[0] <= i_cfg_data;
                    stt_pkg::CFG_DLY2:   r_dly[1] <= i_cfg_data;
                    stt_pkg::CFG_DLY3:   r_dly[2] <= i_cfg_data;
                    stt_pkg::CFG_DLY4:   r_dly[3] <= i_cfg_data;
                    stt_pkg::CFG_RETAIN: r_ret    <= i_cfg_data;
                    default: ;
                endcase
            end
            if (i_cmd.load_tick) begin
                r_clk   <= stt_pkg::add_sat(r_clk, 32'd1);
                r_pendv <= 1'b0;
            end
            if (i_cmd.upd) begin
                r_valid[r_tgt] <= 1'b1;
            end
            if (i_cmd.tk_ev) begin
                if (tk_purge) begin
                    r_valid[r_cnt] <= 1'b0;
                end
                if (tk_due) begin
                    r_pendv <= 1'b1;
                end
            end
        end
    end

    // payload and scan registers
    always_ff @(posedge i_clk) begin
        if (i_cmd.load_hear || i_cmd.load_tick) begin
            r_lo   <= lo_norm;
            r_hi   <= hi_norm;
            r_ov   <= i_in.overlay;
            r_suf  <= i_in.call_suffix;
            r_pos  <= i_in.has_position;
            r_dvok <= dv_ok;
            r_dv   <= dv_val;
            r_cnt  <= '0;
            r_m1f  <= 1'b0;
            r_m2f  <= 1'b0;
            r_m3f  <= 1'b0;
            r_frf  <= 1'b0;
            r_n    <= '0;
        end
        // lookup pass
        if (i_cmd.lk_ev) begin
            r_cnt <= cnt_nxt;
            if (cur_v && !r_m1f && (r_rd.call_low == r_lo) && (r_rd.call_high == r_hi)
                && (r_rd.overlay == r_ov)) begin
                r_m1f <= 1'b1;
                r_m1  <= r_cnt;
            end
            if (cur_v && !r_m2f && (r_rd.suffix == r_dv) && (r_rd.overlay == r_ov)) begin
                r_m2f <= 1'b1;
                r_m2  <= r_cnt;
            end
            if (cur_v && !r_m3f && (r_rd.suffix == r_dv)) begin
                r_m3f <= 1'b1;
                r_m3  <= r_cnt;
            end
            if (!cur_v && !r_frf) begin
                r_frf <= 1'b1;
                r_fr  <= r_cnt;
            end
            if ((r_cnt == '0) || (r_rd.heard < r_oldh)) begin
                r_old  <= r_cnt;
                r_oldh <= r_rd.heard;
            end
        end
        // choose target entry
        if (i_cmd.decide) begin
            r_new  <= !hit;
            r_tgt  <= hit ? hit_idx : (r_frf ? r_fr : r_old);
            r_cnt  <= '0;
            r_bmp  <= '0;
            r_slot <= CW'(1);
        end
        // corral bitmap of other valid entries
        if (i_cmd.sb_ev) begin
            r_cnt <= cnt_nxt;
            if (cur_v && (r_cnt != r_tgt) && (r_rd.corral != '0)) begin
                r_bmp[r_rd.corral] <= 1'b1;
            end
        end
        if (i_cmd.sl_step) begin
            r_slot <= r_slot + 1'b1;
        end
        // tick scan
        if (i_cmd.tk_ev) begin
            r_cnt <= cnt_nxt;
            if (tk_due) begin
                r_pend <= tk_res;
                r_n    <= r_n + 1'b1;
            end
        end
    end

    // next result word
    stt_pkg::t_res res_nxt;
    logic          res_ld;
    always_comb begin
        res_ld       = 1'b1;
        res_nxt      = '0;
        res_nxt.last = 1'b1;
        priority if (i_cmd.emit_empty) begin
            res_nxt.kind = stt_pkg::KIND_NOCALL;
        end else if (i_cmd.upd) begin
            res_nxt.kind          = stt_pkg::KIND_HEARD;
            res_nxt.entry         = ent_field(r_tgt);
            res_nxt.corral_pos    = up_w.corral;
            res_nxt.repeat_number = 2'd0;
            res_nxt.overlay_out   = up_w.overlay;
            res_nxt.heard_time    = r_clk;
        end else if (i_cmd.tk_ev && tk_due && r_pendv) begin
            res_nxt = r_pend;
        end else if (i_cmd.tk_fin && r_pendv) begin
            res_nxt      = r_pend;
            res_nxt.last = 1'b1;
        end else if (i_cmd.tk_fin) begin
            res_nxt.kind = stt_pkg::KIND_NOREP;
        end else begin
            res_ld = 1'b0;
        end
    end

    // result word
    always_ff @(posedge i_clk) begin
        if (res_ld) begin
            r_res <= res_nxt;
        end
    end

    // status to controller
    assign o_sts.empty     = (i_in.call_low[7:0] == 8'h00);
    assign o_sts.cnt_end   = (r_cnt == IW'(ENTRIES - 1));
    assign o_sts.need_slot = !hit && !r_pos;
    assign o_sts.slot_free = !r_bmp[r_slot];

    assign o_res_valid = r_resv;
    assign o_res       = r_res;

endmodule

`default_nettype wire
